### rtl/core/srwld_pkg.sv
// ----------------------------------------------------------------------------
// srwld_pkg: shared definitions for the reorder window loss detector
// Widths, reset values, event codes and controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package srwld_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int SEQ_W          = 32;
    localparam int LG_W           = 33;
    localparam int WS_W           = 7;
    localparam logic [WS_W-1:0] WS_RESET = 7'd16;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_REORDER = 2'd1,
        EV_DUP     = 2'd2,
        EV_LOST    = 2'd3
    } srwld_ev_t;

    typedef struct packed {
        logic load;
        logic root_rd;
        logic root_cap;
        logic up_rd;
        logic up_cmp;
        logic dn_rd;
        logic dn_cmp;
        logic out_load;
    } srwld_cmd_t;

    typedef struct packed {
        logic hdr;
        logic full;
        logic idx_zero;
        logic parent_gt;
        logic c1_ok;
        logic dn_go;
        logic out_free;
    } srwld_stat_t;

endpackage

`default_nettype wire

### rtl/core/srwld_if.sv
// ----------------------------------------------------------------------------
// srwld_if: channel interfaces
// Packet request channel, result channel and window size write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface srwld_in_if
    import srwld_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             header_ok;
    logic [SEQ_W-1:0] seqno;

    modport source (output valid, output header_ok, output seqno, input ready);
    modport sink   (input valid, input header_ok, input seqno, output ready);
endinterface

interface srwld_res_if
    import srwld_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              event_res;
    logic [SEQ_W-1:0]        released_seqno;
    logic [SEQ_W-1:0]        lost_first;
    logic [SEQ_W-1:0]        lost_last;
    logic signed [LG_W-1:0]  largest_before;
    logic signed [LG_W-1:0]  largest_now;

    modport source (output valid, output event_res, output released_seqno,
                    output lost_first, output lost_last, output largest_before,
                    output largest_now, input ready);
    modport sink   (input valid, input event_res, input released_seqno,
                    input lost_first, input lost_last, input largest_before,
                    input largest_now, output ready);
endinterface

interface srwld_cfg_if
    import srwld_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [WS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/srwld_ram.sv
// ----------------------------------------------------------------------------
// srwld_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srwld_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [AW-1:0]        raddr_a,
    output logic      [WIDTH-1:0]     rdata_a,
    input  wire logic [AW-1:0]        raddr_b,
    output logic      [WIDTH-1:0]     rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### rtl/core/srwld_ctrl.sv
// ----------------------------------------------------------------------------
// srwld_ctrl: sequencing controller
// Steps one request through root read, heap sift-down or sift-up, and result
// hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module srwld_ctrl
    import srwld_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire srwld_stat_t stat,
    output srwld_cmd_t       cmd
);
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_ROOT_RD  = 8'b0000_0010,
        S_ROOT_CMP = 8'b0000_0100,
        S_DN_RD    = 8'b0000_1000,
        S_DN_CMP   = 8'b0001_0000,
        S_UP_RD    = 8'b0010_0000,
        S_UP_CMP   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } srwld_state_t;

    srwld_state_t state_reg;
    srwld_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    priority if (!stat.hdr)
                        state_next = S_DONE;
                    else if (stat.full)
                        state_next = S_ROOT_RD;
                    else
                        state_next = S_UP_RD;
                end
            end
            S_ROOT_RD:
            begin
                cmd.root_rd = 1'b1;
                state_next  = S_ROOT_CMP;
            end
            S_ROOT_CMP:
            begin
                cmd.root_cap = 1'b1;
                state_next   = S_DN_RD;
            end
            S_DN_RD:
            begin
                cmd.dn_rd  = 1'b1;
                state_next = stat.c1_ok ? S_DN_CMP : S_DONE;
            end
            S_DN_CMP:
            begin
                cmd.dn_cmp = 1'b1;
                state_next = stat.dn_go ? S_DN_RD : S_DONE;
            end
            S_UP_RD:
            begin
                cmd.up_rd  = 1'b1;
                state_next = stat.idx_zero ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                cmd.up_cmp = 1'b1;
                state_next = stat.parent_gt ? S_UP_RD : S_DONE;
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/srwld_dp.sv
// ----------------------------------------------------------------------------
// srwld_dp: window datapath
// Min-heap in RAM, release classification, window size register and result
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srwld_dp
    import srwld_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire srwld_cmd_t       cmd,
    output srwld_stat_t           stat,
    input  wire logic             hdr_in,
    input  wire logic [SEQ_W-1:0] seqno_in,
    srwld_cfg_if.sink             cfg,
    srwld_res_if.source           res
);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int EW = (CW > WS_W) ? CW : WS_W;
    localparam int XW = AW + 2;

    logic [WS_W-1:0]        ws_reg;
    logic [CW-1:0]          cnt_reg;
    logic [SEQ_W-1:0]       lg_reg;
    logic                   any_reg;
    logic [SEQ_W-1:0]       key_reg;
    logic [AW-1:0]          idx_reg;
    srwld_ev_t              ev_reg;
    logic [SEQ_W-1:0]       rel_reg;
    logic [SEQ_W-1:0]       lf_reg;
    logic [SEQ_W-1:0]       ll_reg;
    logic [LG_W-1:0]        lb_reg;

    logic                   out_vld_reg;
    srwld_ev_t              out_ev_reg;
    logic [SEQ_W-1:0]       out_rel_reg;
    logic [SEQ_W-1:0]       out_lf_reg;
    logic [SEQ_W-1:0]       out_ll_reg;
    logic [LG_W-1:0]        out_lb_reg;
    logic [LG_W-1:0]        out_ln_reg;

    logic [EW-1:0]          ws_x;
    logic [EW-1:0]          eff;
    logic [XW-1:0]          cnt_x;
    logic [XW-1:0]          c1;
    logic [XW-1:0]          c2;
    logic                   c1_ok;
    logic                   c2_ok;
    logic                   b_sel;
    logic [SEQ_W-1:0]       small_v;
    logic [AW-1:0]          small_idx;
    logic [AW-1:0]          parent;
    logic [LG_W-1:0]        lg_prior;
    logic [LG_W-1:0]        now_lg;
    logic                   out_free;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [SEQ_W-1:0]       wdata;
    logic [AW-1:0]          raddr_a;
    logic [AW-1:0]          raddr_b;
    logic [SEQ_W-1:0]       rdata_a;
    logic [SEQ_W-1:0]       rdata_b;

    srwld_ev_t              rl_ev;
    logic [SEQ_W-1:0]       rl_lf;
    logic [SEQ_W-1:0]       rl_ll;
    logic                   rl_raise;

    srwld_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        ws_x      = EW'(ws_reg);
        eff       = (ws_x == '0) ? EW'(1)
                  : ((ws_x > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : ws_x);
        cnt_x     = XW'(cnt_reg);
        c1        = XW'({idx_reg, 1'b0}) + XW'(1);
        c2        = XW'({idx_reg, 1'b0}) + XW'(2);
        c1_ok     = c1 < cnt_x;
        c2_ok     = c2 < cnt_x;
        b_sel     = c2_ok && (rdata_b < rdata_a);
        small_v   = b_sel ? rdata_b : rdata_a;
        small_idx = b_sel ? c2[AW-1:0] : c1[AW-1:0];
        parent    = AW'((idx_reg - AW'(1)) >> 1);
        lg_prior  = any_reg ? {1'b0, lg_reg} : '1;
        now_lg    = any_reg ? {1'b0, lg_reg} : '1;
        out_free  = !out_vld_reg || res.ready;

        stat.hdr       = hdr_in;
        stat.full      = (EW'(cnt_reg) >= eff) && (cnt_reg != '0);
        stat.idx_zero  = (idx_reg == '0);
        stat.parent_gt = rdata_a > key_reg;
        stat.c1_ok     = c1_ok;
        stat.dn_go     = small_v < key_reg;
        stat.out_free  = out_free;
    end

    // classify the released entry against the largest released so far
    always_comb
    begin
        rl_ev    = EV_NONE;
        rl_lf    = '0;
        rl_ll    = '0;
        rl_raise = 1'b0;
        if (!any_reg)
        begin
            rl_raise = 1'b1;
            if (rdata_a != '0)
            begin
                rl_ev = EV_LOST;
                rl_ll = rdata_a - SEQ_W'(1);
            end
        end
        else
        begin
            priority if (rdata_a < lg_reg)
                rl_ev = EV_REORDER;
            else if (rdata_a == lg_reg)
                rl_ev = EV_DUP;
            else
            begin
                rl_raise = 1'b1;
                if ((rdata_a - lg_reg) != SEQ_W'(1))
                begin
                    rl_ev = EV_LOST;
                    rl_lf = lg_reg + SEQ_W'(1);
                    rl_ll = rdata_a - SEQ_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        raddr_a = c1[AW-1:0];
        raddr_b = c2[AW-1:0];
        if (cmd.root_rd)
            raddr_a = '0;
        else if (cmd.up_rd)
            raddr_a = parent;

        we    = 1'b0;
        waddr = idx_reg;
        wdata = key_reg;
        if (cmd.up_rd && stat.idx_zero)
        begin
            we = 1'b1;
        end
        if (cmd.up_cmp)
        begin
            we    = 1'b1;
            wdata = stat.parent_gt ? rdata_a : key_reg;
        end
        if (cmd.dn_rd && !c1_ok)
        begin
            we = 1'b1;
        end
        if (cmd.dn_cmp)
        begin
            we    = 1'b1;
            wdata = stat.dn_go ? small_v : key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg      <= WS_RESET;
            cnt_reg     <= '0;
            lg_reg      <= '0;
            any_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                ws_reg <= cfg.data;
            end
            if (cmd.load && hdr_in && !stat.full)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.root_cap && rl_raise)
            begin
                lg_reg  <= rdata_a;
                any_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= seqno_in;
            lb_reg  <= lg_prior;
            ev_reg  <= EV_NONE;
            rel_reg <= '0;
            lf_reg  <= '0;
            ll_reg  <= '0;
            idx_reg <= AW'(cnt_reg);
        end
        if (cmd.root_cap)
        begin
            ev_reg  <= rl_ev;
            rel_reg <= rdata_a;
            lf_reg  <= rl_lf;
            ll_reg  <= rl_ll;
            idx_reg <= '0;
        end
        if (cmd.up_cmp && stat.parent_gt)
        begin
            idx_reg <= parent;
        end
        if (cmd.dn_cmp && stat.dn_go)
        begin
            idx_reg <= small_idx;
        end
        if (cmd.out_load)
        begin
            out_ev_reg  <= ev_reg;
            out_rel_reg <= rel_reg;
            out_lf_reg  <= lf_reg;
            out_ll_reg  <= ll_reg;
            out_lb_reg  <= lb_reg;
            out_ln_reg  <= now_lg;
        end
    end

    assign cfg.ready          = 1'b1;
    assign res.valid          = out_vld_reg;
    assign res.event_res      = out_ev_reg;
    assign res.released_seqno = out_rel_reg;
    assign res.lost_first     = out_lf_reg;
    assign res.lost_last      = out_ll_reg;
    assign res.largest_before = out_lb_reg;
    assign res.largest_now    = out_ln_reg;

endmodule

`default_nettype wire

### rtl/core/seqno_reorder_window_loss_detector_unit.sv
// ----------------------------------------------------------------------------
// seqno_reorder_window_loss_detector_unit: reorder window and loss detector
// Holds received sequence numbers in a min-heap window and reports large
// reorders, duplicates and lost ranges as the smallest entry is released.
// ----------------------------------------------------------------------------
// One packet request is taken at a time. A request with an invalid header
// goes straight to result hand-off. A request that only inserts sifts up
// through UP_RD and UP_CMP for each heap level climbed; a request that
// releases the smallest entry reads the root in ROOT_RD and ROOT_CMP, then
// sifts down through DN_RD and DN_CMP for each heap level descended.
// The heap sift walks each level with a read state and a compare state on
// the one-write, two-read window RAM. The result sits in an output register,
// so the next request is accepted while the last result waits. The window
// size register is to be written only while the unit is idle; the block
// itself does not enforce it. A value of 0 acts as 1 and a value above
// MAX_WINDOW acts as MAX_WINDOW.
`default_nettype none

module seqno_reorder_window_loss_detector_unit
    import srwld_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    srwld_cfg_if.sink   cfg,
    srwld_in_if.sink    pkt,
    srwld_res_if.source evt
);
    srwld_cmd_t  cmd;
    srwld_stat_t stat;

    srwld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pkt.valid),
        .in_ready (pkt.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srwld_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .hdr_in   (pkt.header_ok),
        .seqno_in (pkt.seqno),
        .cfg      (cfg),
        .res      (evt)
    );

endmodule

`default_nettype wire

### verif/srwld_event_checker.sv
// ----------------------------------------------------------------------------
// srwld_event_checker: window event predictor and result checker
// Watches the packet, result and window size channels of the reorder window
// loss detector. Mirrors the window contents and the largest released
// sequence number, works out the event for every accepted packet request,
// and compares each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module srwld_event_checker
    import srwld_pkg::*;
#(
    parameter int MAX_WIN = MAX_WINDOW_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    srwld_cfg_if      cfg,
    srwld_in_if       pkt,
    srwld_res_if      evt,
    output int        fail_count,
    output int        pending,
    output int        n_results,
    output int        n_cfg,
    output int        n_none,
    output int        n_reorder,
    output int        n_dup,
    output int        n_lost
);

    typedef struct {
        srwld_ev_t              ev;
        logic [SEQ_W-1:0]       released;
        logic [SEQ_W-1:0]       first_lost;
        logic [SEQ_W-1:0]       last_lost;
        logic signed [LG_W-1:0] top_before;
        logic signed [LG_W-1:0] top_now;
    } window_event_t;

    logic [SEQ_W-1:0] win_mem [MAX_WIN];
    int               win_count;
    logic [SEQ_W-1:0] top_released;
    logic             any_released;
    logic [WS_W-1:0]  win_size;
    window_event_t    event_q [$];
    window_event_t    want;

    assign pending = event_q.size();

    function automatic window_event_t predict_event(input logic hdr,
                                                    input logic [SEQ_W-1:0] seq);
        window_event_t r;
        int            lim;
        int            best;
        logic [SEQ_W-1:0] v;
        longint        b;
        longint        vs;
        longint        nb;
        r.ev         = EV_NONE;
        r.released   = '0;
        r.first_lost = '0;
        r.last_lost  = '0;
        b = any_released ? longint'({32'd0, top_released}) : -64'sd1;
        r.top_before = b[LG_W-1:0];
        if (hdr) begin
            lim = int'(win_size);
            if (lim < 1)
                lim = 1;
            if (lim > MAX_WIN)
                lim = MAX_WIN;
            if (win_count >= lim && win_count > 0) begin
                best = 0;
                for (int i = 1; i < win_count; i++)
                begin
                    if (win_mem[i] < win_mem[best])
                        best = i;
                end
                v = win_mem[best];
                win_count--;
                win_mem[best] = win_mem[win_count];
                vs = longint'({32'd0, v});
                r.released = v;
                if (vs < b)
                    r.ev = EV_REORDER;
                else if (vs == b)
                    r.ev = EV_DUP;
                else if (vs > b + 1)
                begin
                    r.ev = EV_LOST;
                    nb = b + 1;
                    r.first_lost = nb[SEQ_W-1:0];
                    r.last_lost  = v - 1;
                end
                if (vs > b)
                begin
                    top_released = v;
                    any_released = 1'b1;
                end
            end
            if (win_count < MAX_WIN)
            begin
                win_mem[win_count] = seq;
                win_count++;
            end
        end
        b = any_released ? longint'({32'd0, top_released}) : -64'sd1;
        r.top_now = b[LG_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [LG_W-1:0] exp_v,
                               input logic [LG_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %h, actual %h",
                     $time, fname, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_count    = 0;
            top_released = '0;
            any_released = 1'b0;
            win_size     = WS_RESET;
            event_q.delete();
            fail_count   = 0;
            n_results    = 0;
            n_cfg        = 0;
            n_none       = 0;
            n_reorder    = 0;
            n_dup        = 0;
            n_lost       = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                win_size = cfg.data;
                n_cfg++;
            end
            if (pkt.valid && pkt.ready)
                event_q.push_back(predict_event(pkt.header_ok, pkt.seqno));
            if (evt.valid && evt.ready)
            begin
                n_results++;
                if (event_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual event %0d released %h",
                             $time, evt.event_res, evt.released_seqno);
                end
                else
                begin
                    want = event_q.pop_front();
                    check_field("event_res", want.ev, evt.event_res);
                    check_field("released_seqno", want.released, evt.released_seqno);
                    check_field("lost_first", want.first_lost, evt.lost_first);
                    check_field("lost_last", want.last_lost, evt.lost_last);
                    check_field("largest_before", want.top_before, evt.largest_before);
                    check_field("largest_now", want.top_now, evt.largest_now);
                    case (want.ev)
                        EV_NONE:    n_none++;
                        EV_REORDER: n_reorder++;
                        EV_DUP:     n_dup++;
                        default:    n_lost++;
                    endcase
                end
            end
        end
    end

endmodule

`default_nettype wire

### verif/tb_seqno_reorder_window_loss_detector_unit.sv
// ----------------------------------------------------------------------------
// tb_seqno_reorder_window_loss_detector_unit: regression for the detector
// Drives packet requests and window size writes with random gaps and result
// back-pressure, including a long result stall and a stretch without gaps.
// A directed opening covers invalid headers, the first release, duplicates,
// reorders, lost ranges at the number extremes and a lowered window size;
// random phases follow with mostly in-order streams over several sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_seqno_reorder_window_loss_detector_unit;
    import srwld_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;

    srwld_in_if  pkt_if ();
    srwld_res_if evt_if ();
    srwld_cfg_if cfg_if ();

    int chk_fail;
    int chk_pending;
    int chk_results;
    int chk_cfg;
    int chk_none;
    int chk_reorder;
    int chk_dup;
    int chk_lost;

    int               sent_count;
    bit               tx_idle_en;
    bit               rx_idle_en;
    bit               hold_req;
    logic [SEQ_W-1:0] cur_seq;
    logic [SEQ_W-1:0] last_seq;

    seqno_reorder_window_loss_detector_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .pkt   (pkt_if),
        .evt   (evt_if)
    );

    srwld_event_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .pkt        (pkt_if),
        .evt        (evt_if),
        .fail_count (chk_fail),
        .pending    (chk_pending),
        .n_results  (chk_results),
        .n_cfg      (chk_cfg),
        .n_none     (chk_none),
        .n_reorder  (chk_reorder),
        .n_dup      (chk_dup),
        .n_lost     (chk_lost)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_pkt(input logic hdr, input logic [SEQ_W-1:0] seq);
        pkt_if.valid     <= 1'b1;
        pkt_if.header_ok <= hdr;
        pkt_if.seqno     <= seq;
        @(posedge clk);
        while (!pkt_if.ready)
            @(posedge clk);
        sent_count++;
        while (tx_idle_en && $urandom_range(0, 99) < 27)
        begin
            pkt_if.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // hold requests until every result is back, then write the size
    task automatic write_ws(input logic [WS_W-1:0] ws);
        pkt_if.valid <= 1'b0;
        while (chk_results < sent_count)
            @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= ws;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_random_item();
        int               r;
        logic [SEQ_W-1:0] s;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_pkt(1'b0, $urandom());
        else
        begin
            if (r < 13)
                s = $urandom();
            else if (r < 20)
                s = last_seq;
            else if (r < 28)
                s = cur_seq - $urandom_range(1, 20);
            else if (r < 36)
            begin
                cur_seq = cur_seq + $urandom_range(2, 40);
                s = cur_seq;
            end
            else
            begin
                cur_seq = cur_seq + 1;
                s = cur_seq;
            end
            last_seq = s;
            send_pkt(1'b1, s);
        end
    endtask

    task automatic run_phase(input logic [WS_W-1:0] ws, input int n_items, input bit hold);
        int pick;
        write_ws(ws);
        if (hold)
            hold_req = 1'b1;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            cur_seq = 32'hFFFF_FFC0;
        else if (pick == 1)
            cur_seq = '0;
        else
            cur_seq = $urandom();
        last_seq = cur_seq;
        repeat (n_items)
            send_random_item();
    endtask

    initial
    begin
        int k;
        evt_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                evt_if.ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else
                evt_if.ready <= (!rx_idle_en || $urandom_range(0, 99) >= 27);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pkt_if.valid && pkt_if.ready) || (evt_if.valid && evt_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("seqno_reorder_window_loss_detector_unit regression: fail");
        $finish;
    end

    initial
    begin
        pkt_if.valid     = 1'b0;
        pkt_if.header_ok = 1'b0;
        pkt_if.seqno     = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = '0;
        rst_n            = 1'b0;
        sent_count       = 0;
        tx_idle_en       = 1'b1;
        rx_idle_en       = 1'b1;
        hold_req         = 1'b0;
        cur_seq          = '0;
        last_seq         = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // release on every valid request after the first
        write_ws(7'd1);
        send_pkt(1'b0, 32'hFFFF_FFFF);
        send_pkt(1'b1, 32'd7);
        send_pkt(1'b1, 32'd7);
        send_pkt(1'b1, 32'd7);
        send_pkt(1'b1, 32'd3);
        send_pkt(1'b0, 32'd0);
        send_pkt(1'b1, 32'hFFFF_FFFF);
        send_pkt(1'b1, 32'hFFFF_FFFF);
        send_pkt(1'b1, 32'd0);
        send_pkt(1'b1, 32'h8000_0000);
        send_pkt(1'b1, 32'd1);

        write_ws(7'd4);
        send_pkt(1'b1, 32'd10);
        send_pkt(1'b1, 32'd12);
        send_pkt(1'b1, 32'd11);
        send_pkt(1'b1, 32'd9);
        send_pkt(1'b1, 32'd20);
        send_pkt(1'b1, 32'd21);

        // shrink below the held count
        write_ws(7'd0);
        send_pkt(1'b1, 32'd22);
        send_pkt(1'b1, 32'd24);
        send_pkt(1'b1, 32'd23);
        send_pkt(1'b0, 32'h5555_AAAA);

        run_phase(7'd64, 90, 1'b0);
        run_phase(7'd127, 40, 1'b1);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_phase(7'd1, 50, 1'b0);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_phase(7'd0, 40, 1'b0);
        run_phase(7'd8, 60, 1'b0);
        run_phase(7'd3, 50, 1'b0);
        run_phase(7'd33, 60, 1'b0);
        run_phase(7'($urandom_range(0, 127)), 60, 1'b0);
        run_phase(7'($urandom_range(0, 127)), 60, 1'b0);
        run_phase(7'd16, 50, 1'b0);

        pkt_if.valid <= 1'b0;
        while (chk_results < sent_count)
            @(posedge clk);
        repeat (40)
            @(posedge clk);

        $display("covered %0d packet requests and %0d window size writes",
                 sent_count, chk_cfg);
        $display("events seen: none %0d, large reorder %0d, duplicate %0d, lost range %0d",
                 chk_none, chk_reorder, chk_dup, chk_lost);
        if (chk_fail == 0 && chk_pending == 0)
            $display("seqno_reorder_window_loss_detector_unit regression: pass");
        else
            $display("seqno_reorder_window_loss_detector_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
